>>> rtl/asdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_pkg: shared types and constants of the angular spring-damper block
// Holds the register map, the stage records that travel between the
// pipeline sections, the fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package asdm_pkg;

	// Register map, by word index on the configuration port.
	typedef enum logic [2:0] {
		REG_REF_X     = 3'd0,
		REG_REF_Y     = 3'd1,
		REG_REF_Z     = 3'd2,
		REG_STIFFNESS = 3'd3,
		REG_DAMPING   = 3'd4,
		REG_THRESHOLD = 3'd5
	} reg_idx_t;

	localparam int unsigned CORDIC_STEPS = 30;
	localparam int unsigned DIV_STEPS    = 31;
	localparam int unsigned SQRT_STEPS   = 32;

	localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic [30:0]        ANGLE_MAX   = 31'd1686629713;

	// Front section result: cross product, dot product and squared terms.
	typedef struct packed {
		logic             vld;
		logic [2:0][33:0] a;
		logic [31:0]      dot;
		logic [63:0]      m2;
		logic [63:0]      s2;
		logic [2:0][31:0] om;
	} front_t;

	// Square-root section result: cross magnitude and sine of the angle.
	typedef struct packed {
		logic             vld;
		logic [2:0][33:0] a;
		logic [31:0]      dot;
		logic [31:0]      mag;
		logic [31:0]      sn;
		logic [2:0][31:0] om;
	} sqrt_t;

	// Iterative section record: axis division lanes plus the CORDIC vector.
	typedef struct packed {
		logic             vld;
		logic             aligned;
		logic [2:0]       neg;
		logic [31:0]      mag;
		logic [2:0][32:0] rem;
		logic [2:0][30:0] q;
		logic [2:0][30:0] lo;
		logic signed [61:0] x;
		logic signed [61:0] y;
		logic signed [34:0] z;
		logic [2:0][31:0] om;
	} iter_t;

	// Saturate a Q1.30 value to [-1, 1].
	function automatic logic signed [31:0] sat_unit(input logic signed [31:0] v);
		if (v > Q30_ONE) begin
			return Q30_ONE;
		end else if (v < -Q30_ONE) begin
			return -Q30_ONE;
		end
		return v;
	endfunction

	// Saturate a wide value to the Q1.30 unit range.
	function automatic logic signed [31:0] sat_wide(input logic signed [63:0] v);
		if (v > 64'sd1073741824) begin
			return Q30_ONE;
		end else if (v < -64'sd1073741824) begin
			return -Q30_ONE;
		end
		return v[31:0];
	endfunction

	// CORDIC arctangent table, Q1.30.
	function automatic logic [31:0] atan_tab(input int unsigned k);
		case (k)
			0:  return 32'h3243F6A8;
			1:  return 32'h1DAC6705;
			2:  return 32'h0FADBAFC;
			3:  return 32'h07F56EA6;
			4:  return 32'h03FEAB76;
			5:  return 32'h01FFD55B;
			6:  return 32'h00FFFAAA;
			7:  return 32'h007FFF55;
			8:  return 32'h003FFFEA;
			9:  return 32'h001FFFFD;
			10: return 32'h000FFFFF;
			11: return 32'h0007FFFF;
			12: return 32'h0003FFFF;
			13: return 32'h0001FFFF;
			14: return 32'h0000FFFF;
			15: return 32'h00007FFF;
			16: return 32'h00003FFF;
			17: return 32'h00001FFF;
			18: return 32'h00000FFF;
			19: return 32'h000007FF;
			20: return 32'h000003FF;
			21: return 32'h000001FF;
			22: return 32'h000000FF;
			23: return 32'h0000007F;
			24: return 32'h0000003F;
			25: return 32'h0000001F;
			26: return 32'h0000000F;
			27: return 32'h00000008;
			28: return 32'h00000004;
			29: return 32'h00000002;
			default: return 32'h00000000;
		endcase
	endfunction

endpackage

>>> rtl/asdm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_front: rotation, cross product and dot product stages
// Six register stages: rotate the reference direction, form d x c and
// c . d, and square the terms that feed the two square roots.
// ----------------------------------------------------------------------------
module asdm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic [8:0][31:0]      rot,
	input  logic [2:0][31:0]      om,
	input  logic [2:0][31:0]      dir,
	output asdm_pkg::front_t      out
);
	import asdm_pkg::*;

	logic signed [31:0] rs [9];
	logic signed [31:0] ds [3];

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [63:0] p_s1 [9];
	logic [2:0][31:0]   om_s1, om_s2, om_s3, om_s4, om_s5;
	logic signed [31:0] c_n  [3];
	logic signed [31:0] c_s2 [3];
	logic signed [63:0] x_s3 [6];
	logic signed [63:0] dp_s3 [3];
	logic signed [33:0] a_n  [3];
	logic signed [31:0] dot_n;
	logic signed [33:0] a_s4 [3];
	logic signed [31:0] dot_s4;
	logic signed [33:0] a_s5 [3];
	logic [63:0]        sq_s5 [3];
	logic [63:0]        dsq_s5;
	logic signed [31:0] dot_s5;

	// Saturate the matrix entries and the reference direction.
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			rs[i] = sat_unit(rot[i]);
		end
		for (int j = 0; j < 3; j++) begin
			ds[j] = sat_unit(dir[j]);
		end
	end

	// Stage 1: the nine products of R*d.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[3*i+j] <= rs[3*i+j] * ds[j];
				end
			end
			om_s1 <= om;
		end
	end

	// Rotated direction, rounded and saturated to Q1.30.
	always_comb begin
		logic signed [63:0] sumv;
		for (int i = 0; i < 3; i++) begin
			sumv = p_s1[3*i] + p_s1[3*i+1] + p_s1[3*i+2];
			c_n[i] = sat_wide((sumv + 64'sd536870912) >>> 30);
		end
	end

	// Stage 2: rotated direction c.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			c_s2   <= c_n;
			om_s2  <= om_s1;
		end
	end

	// Stage 3: products for the cross and the dot product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3   <= vld_s2;
			x_s3[0]  <= ds[1] * c_s2[2];
			x_s3[1]  <= ds[2] * c_s2[1];
			x_s3[2]  <= ds[2] * c_s2[0];
			x_s3[3]  <= ds[0] * c_s2[2];
			x_s3[4]  <= ds[0] * c_s2[1];
			x_s3[5]  <= ds[1] * c_s2[0];
			for (int i = 0; i < 3; i++) begin
				dp_s3[i] <= c_s2[i] * ds[i];
			end
			om_s3 <= om_s2;
		end
	end

	// Round the cross product and the dot product to Q1.30.
	always_comb begin
		logic signed [63:0] rnd;
		for (int i = 0; i < 3; i++) begin
			rnd = (x_s3[2*i] - x_s3[2*i+1] + 64'sd536870912) >>> 30;
			a_n[i] = rnd[33:0];
		end
		dot_n = sat_wide((dp_s3[0] + dp_s3[1] + dp_s3[2] + 64'sd536870912) >>> 30);
	end

	// Stage 4: cross product a and dot product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
			a_s4   <= a_n;
			dot_s4 <= dot_n;
			om_s4  <= om_s3;
		end
	end

	// Stage 5: squares of the cross components and of the dot product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= a_s4[i] * a_s4[i];
			end
			dsq_s5 <= dot_s4 * dot_s4;
			a_s5   <= a_s4;
			dot_s5 <= dot_s4;
			om_s5  <= om_s4;
		end
	end

	// Stage 6: squared magnitude and squared sine, as square-root operands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out.vld <= 1'b0;
		end else begin
			out.vld <= vld_s5;
			for (int i = 0; i < 3; i++) begin
				out.a[i] <= a_s5[i];
			end
			out.dot <= dot_s5;
			out.m2  <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			out.s2  <= 64'h1000_0000_0000_0000 - dsq_s5;
			out.om  <= om_s5;
		end
	end

endmodule

>>> rtl/asdm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_sqrt: pipelined integer square roots
// Two digit-by-digit square-root lanes, four steps per register stage:
// one for the cross magnitude and one for the sine of the angle.
// ----------------------------------------------------------------------------
module asdm_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  asdm_pkg::front_t in,
	output asdm_pkg::sqrt_t  out
);
	import asdm_pkg::*;

	localparam int unsigned STEPS_PER = 4;
	localparam int unsigned NSTAGE    = SQRT_STEPS / STEPS_PER;

	typedef struct packed {
		logic             vld;
		logic [2:0][33:0] a;
		logic [31:0]      dot;
		logic [63:0]      v0;
		logic [63:0]      r0;
		logic [63:0]      v1;
		logic [63:0]      r1;
		logic [2:0][31:0] om;
	} sq_st_t;

	sq_st_t head;
	sq_st_t pipe_s [1:NSTAGE];

	// Load both lanes from the front section.
	always_comb begin
		head.vld = in.vld;
		head.a   = in.a;
		head.dot = in.dot;
		head.v0  = in.m2;
		head.r0  = '0;
		head.v1  = in.s2;
		head.r1  = '0;
		head.om  = in.om;
	end

	for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
		sq_st_t cur;
		sq_st_t nxt;

		// The first stage takes the loaded operands, later ones the previous stage.
		if (g == 0) begin : g_head
			assign cur = head;
		end else begin : g_body
			assign cur = pipe_s[g];
		end

		// Four root digits per stage in each lane.
		always_comb begin
			logic [63:0] b;
			nxt = cur;
			for (int j = 0; j < STEPS_PER; j++) begin
				b = 64'd1 << (62 - 2 * (g * STEPS_PER + j));
				if (nxt.v0 >= nxt.r0 + b) begin
					nxt.v0 = nxt.v0 - (nxt.r0 + b);
					nxt.r0 = (nxt.r0 >> 1) + b;
				end else begin
					nxt.r0 = nxt.r0 >> 1;
				end
				if (nxt.v1 >= nxt.r1 + b) begin
					nxt.v1 = nxt.v1 - (nxt.r1 + b);
					nxt.r1 = (nxt.r1 >> 1) + b;
				end else begin
					nxt.r1 = nxt.r1 >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_s[g+1].vld <= 1'b0;
			end else begin
				pipe_s[g+1] <= nxt;
			end
		end
	end

	// Roots fit in 32 bits once all digits are done.
	always_comb begin
		out.vld = pipe_s[NSTAGE].vld;
		out.a   = pipe_s[NSTAGE].a;
		out.dot = pipe_s[NSTAGE].dot;
		out.mag = pipe_s[NSTAGE].r0[31:0];
		out.sn  = pipe_s[NSTAGE].r1[31:0];
		out.om  = pipe_s[NSTAGE].om;
	end

endmodule

>>> rtl/asdm_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_iter: axis normalization and angle CORDIC
// A setup stage, then sixteen stages of up to two steps each: three restoring
// division lanes for the unit axis and a vectoring CORDIC for the angle.
// ----------------------------------------------------------------------------
module asdm_iter (
	input  logic             clk,
	input  logic             arst_n,
	input  asdm_pkg::sqrt_t  in,
	input  logic [30:0]      thr,
	output asdm_pkg::iter_t  out
);
	import asdm_pkg::*;

	localparam int unsigned STEPS_PER = 2;
	localparam int unsigned NSTAGE    = (DIV_STEPS + STEPS_PER - 1) / STEPS_PER;

	iter_t pipe_s [NSTAGE+1];
	iter_t prep;

	// Setup: alignment test, division operands and the starting vector.
	always_comb begin
		logic signed [33:0] av;
		logic [33:0]        ua;
		logic [63:0]        num;
		logic signed [61:0] x0;
		logic signed [61:0] y0;
		prep.vld     = in.vld;
		prep.aligned = (in.mag <= {1'b0, thr});
		prep.mag     = in.mag;
		for (int i = 0; i < 3; i++) begin
			av = in.a[i];
			ua = (av < 0) ? 34'(-av) : 34'(av);
			num = ({30'b0, ua} << 30) + {33'b0, in.mag[31:1]};
			prep.neg[i] = av[33];
			prep.rem[i] = {1'b0, num[62:31]};
			prep.lo[i]  = num[30:0];
			prep.q[i]   = '0;
		end
		x0 = {{2{in.dot[31]}}, in.dot, 28'b0};
		y0 = {2'b0, in.sn, 28'b0};
		if (x0 < 0) begin
			prep.x = y0;
			prep.y = -x0;
			prep.z = HALF_PI_Q30;
		end else begin
			prep.x = x0;
			prep.y = y0;
			prep.z = '0;
		end
		prep.om = in.om;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s[0].vld <= 1'b0;
		end else begin
			pipe_s[0] <= prep;
		end
	end

	for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
		iter_t nxt;

		// Up to two division digits and two CORDIC rotations per stage.
		always_comb begin
			logic [32:0]        remv;
			logic signed [61:0] dx;
			logic signed [61:0] dy;
			logic signed [34:0] at;
			int unsigned        k;
			nxt = pipe_s[g];
			for (int j = 0; j < STEPS_PER; j++) begin
				k = g * STEPS_PER + j;
				if (k < DIV_STEPS) begin
					for (int i = 0; i < 3; i++) begin
						remv = {nxt.rem[i][31:0], nxt.lo[i][DIV_STEPS-1-k]};
						if (remv >= {1'b0, nxt.mag}) begin
							nxt.rem[i] = remv - {1'b0, nxt.mag};
							nxt.q[i]   = {nxt.q[i][29:0], 1'b1};
						end else begin
							nxt.rem[i] = remv;
							nxt.q[i]   = {nxt.q[i][29:0], 1'b0};
						end
					end
				end
				if (k < CORDIC_STEPS) begin
					dx = nxt.x >>> k;
					dy = nxt.y >>> k;
					at = $signed({3'b0, atan_tab(k)});
					if (nxt.y > 62'sd0) begin
						nxt.x = nxt.x + dy;
						nxt.y = nxt.y - dx;
						nxt.z = nxt.z + at;
					end else begin
						nxt.x = nxt.x - dy;
						nxt.y = nxt.y + dx;
						nxt.z = nxt.z - at;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_s[g+1].vld <= 1'b0;
			end else begin
				pipe_s[g+1] <= nxt;
			end
		end
	end

	assign out = pipe_s[NSTAGE];

endmodule

>>> rtl/asdm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdm_back: spring and damping terms with output saturation
// Five register stages: angle clamp, gain products, rounding, and the
// saturated moment, which stands in the last stage as the result.
// ----------------------------------------------------------------------------
module asdm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  asdm_pkg::iter_t  in,
	input  logic [31:0]      stiffness,
	input  logic [31:0]      damping,
	output logic             done,
	output logic [2:0][47:0] moment,
	output logic [30:0]      angle,
	output logic             aligned
);
	import asdm_pkg::*;

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic             al_s1, al_s2, al_s3, al_s4;
	logic [30:0]      th_n;
	logic [30:0]      th_s1, th_s2, th_s3, th_s4;
	logic [2:0][30:0] axm_s1, axm_s2, axm_s3;
	logic [2:0]       nax_s1, nax_s2, nax_s3, nax_s4;
	logic [2:0]       nom_s1, nom_s2, nom_s3, nom_s4;
	logic [2:0][31:0] oab_n;
	logic [2:0][63:0] tdp_s1;
	logic [63:0]      kp_s2;
	logic [2:0][48:0] td_s2, td_s3, td_s4;
	logic [34:0]      k_s3;
	logic [2:0][63:0] sp_s4;
	logic [2:0][47:0] m_n;

	// Clamp the CORDIC angle to [0, pi] and round it to Q2.29.
	always_comb begin
		logic signed [34:0] zc;
		logic [32:0]        zr;
		zc = in.z;
		if (zc < 0) begin
			zc = '0;
		end
		if (zc > PI_Q30) begin
			zc = PI_Q30;
		end
		zr = (zc[32:0] + 33'd1) >> 1;
		if (zr > {2'b0, ANGLE_MAX}) begin
			zr = {2'b0, ANGLE_MAX};
		end
		th_n = in.aligned ? '0 : zr[30:0];
		for (int i = 0; i < 3; i++) begin
			oab_n[i] = in.om[i][31] ? (~in.om[i] + 32'd1) : in.om[i];
		end
	end

	// Stage 1: angle, axis magnitudes and damping products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in.vld;
			al_s1  <= in.aligned;
			th_s1  <= th_n;
			for (int i = 0; i < 3; i++) begin
				axm_s1[i] <= in.aligned ? '0 : in.q[i];
				nax_s1[i] <= in.neg[i] & ~in.aligned;
				nom_s1[i] <= in.om[i][31];
				tdp_s1[i] <= {32'b0, damping} * {32'b0, oab_n[i]};
			end
		end
	end

	// Stage 2: stiffness times angle, rounded damping terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			al_s2  <= al_s1;
			th_s2  <= th_s1;
			axm_s2 <= axm_s1;
			nax_s2 <= nax_s1;
			nom_s2 <= nom_s1;
			kp_s2  <= {33'b0, th_s1} * {32'b0, stiffness};
			for (int i = 0; i < 3; i++) begin
				td_s2[i] <= 49'((tdp_s1[i] + 64'd32768) >> 16);
			end
		end
	end

	// Stage 3: rounded spring gain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			al_s3  <= al_s2;
			th_s3  <= th_s2;
			axm_s3 <= axm_s2;
			nax_s3 <= nax_s2;
			nom_s3 <= nom_s2;
			td_s3  <= td_s2;
			k_s3   <= 35'((kp_s2 + 64'd268435456) >> 29);
		end
	end

	// Stage 4: spring gain times each axis magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
			al_s4  <= al_s3;
			th_s4  <= th_s3;
			nax_s4 <= nax_s3;
			nom_s4 <= nom_s3;
			td_s4  <= td_s3;
			for (int i = 0; i < 3; i++) begin
				sp_s4[i] <= {29'b0, k_s3} * {33'b0, axm_s3[i]};
			end
		end
	end

	// Signed sum of both terms, saturated to 48 bits.
	always_comb begin
		logic [34:0]        ts;
		logic signed [50:0] tsv;
		logic signed [50:0] tdv;
		logic signed [50:0] mv;
		for (int i = 0; i < 3; i++) begin
			ts  = 35'((sp_s4[i] + 64'd536870912) >> 30);
			tsv = nax_s4[i] ? -$signed({16'b0, ts}) : $signed({16'b0, ts});
			tdv = nom_s4[i] ? -$signed({2'b0, td_s4[i]}) : $signed({2'b0, td_s4[i]});
			mv  = -tsv - tdv;
			if (mv > 51'sd140737488355327) begin
				m_n[i] = 48'h7FFF_FFFF_FFFF;
			end else if (mv < -51'sd140737488355328) begin
				m_n[i] = 48'h8000_0000_0000;
			end else begin
				m_n[i] = mv[47:0];
			end
		end
	end

	// Stage 5: result register, shown for one cycle with the strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done    <= vld_s4;
			moment  <= m_n;
			angle   <= th_s4;
			aligned <= al_s4;
		end
	end

endmodule

>>> rtl/angular_spring_damper_moment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angular_spring_damper_moment: restraint moment of an angular spring-damper
// Rotates the reference direction by the body orientation, finds axis and
// angle of the deflection, and returns -stiffness*theta*axis - damping*omega.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+------------------------------
//   command  | start, busy                   | rot_xx..rot_zz, omega_x..z
//   result   | done (one-cycle strobe)       | moment_x..z, angle, aligned
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A transaction enters whenever start is high; busy is always low, so one
// transaction per cycle is taken. Each result passes 6 front stages, 8
// square-root stages, 17 stages of axis division and CORDIC, and 5 gain
// stages. Reset clears only the valid bits and sets the configuration
// registers to their defaults. The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module angular_spring_damper_moment (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] rot_xx,
	input  logic signed [31:0] rot_xy,
	input  logic signed [31:0] rot_xz,
	input  logic signed [31:0] rot_yx,
	input  logic signed [31:0] rot_yy,
	input  logic signed [31:0] rot_yz,
	input  logic signed [31:0] rot_zx,
	input  logic signed [31:0] rot_zy,
	input  logic signed [31:0] rot_zz,
	input  logic signed [31:0] omega_x,
	input  logic signed [31:0] omega_y,
	input  logic signed [31:0] omega_z,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic               done,
	output logic signed [47:0] moment_x,
	output logic signed [47:0] moment_y,
	output logic signed [47:0] moment_z,
	output logic [30:0]        angle,
	output logic               aligned
);
	import asdm_pkg::*;

	logic [31:0]      ref_x_q, ref_y_q, ref_z_q, stiff_q, damp_q;
	logic [30:0]      thr_q;
	reg_idx_t         ridx;
	logic [8:0][31:0] rot_v;
	logic [2:0][31:0] om_v;
	logic [2:0][31:0] dir_v;
	logic [2:0][47:0] mom;
	front_t           front_o;
	sqrt_t            sqrt_o;
	iter_t            iter_o;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	// Configuration registers, written on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q <= 32'h4000_0000;
			ref_y_q <= '0;
			ref_z_q <= '0;
			stiff_q <= '0;
			damp_q  <= '0;
			thr_q   <= 31'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_REF_X:     ref_x_q <= pwdata;
				REG_REF_Y:     ref_y_q <= pwdata;
				REG_REF_Z:     ref_z_q <= pwdata;
				REG_STIFFNESS: stiff_q <= pwdata;
				REG_DAMPING:   damp_q  <= pwdata;
				REG_THRESHOLD: thr_q   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (ridx)
			REG_REF_X:     prdata = ref_x_q;
			REG_REF_Y:     prdata = ref_y_q;
			REG_REF_Z:     prdata = ref_z_q;
			REG_STIFFNESS: prdata = stiff_q;
			REG_DAMPING:   prdata = damp_q;
			REG_THRESHOLD: prdata = {1'b0, thr_q};
			default:       prdata = '0;
		endcase
	end

	// Gather the payload into arrays, matrix in row-major order.
	assign rot_v = {rot_zz, rot_zy, rot_zx, rot_yz, rot_yy, rot_yx, rot_xz, rot_xy, rot_xx};
	assign om_v  = {omega_z, omega_y, omega_x};
	assign dir_v = {ref_z_q, ref_y_q, ref_x_q};

	asdm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.rot    (rot_v),
		.om     (om_v),
		.dir    (dir_v),
		.out    (front_o)
	);

	asdm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (front_o),
		.out    (sqrt_o)
	);

	asdm_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (sqrt_o),
		.thr    (thr_q),
		.out    (iter_o)
	);

	asdm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (iter_o),
		.stiffness (stiff_q),
		.damping   (damp_q),
		.done      (done),
		.moment    (mom),
		.angle     (angle),
		.aligned   (aligned)
	);

	assign moment_x = mom[0];
	assign moment_y = mom[1];
	assign moment_z = mom[2];

	// An aligned result carries no angle.
	a_aligned_no_angle: assert property (@(posedge clk) disable iff (!arst_n)
		done && aligned |-> angle == '0)
		else $error("aligned result with a nonzero angle");

	// The angle never exceeds pi in Q2.29.
	a_angle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> angle <= ANGLE_MAX)
		else $error("angle beyond pi");

	// With zero gains the x and y moment components are zero.
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		done && stiff_q == '0 && damp_q == '0 |-> moment_x == '0 && moment_y == '0)
		else $error("nonzero moment with zero gains");

endmodule

>>> tb/angular_spring_damper_moment_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angular_spring_damper_moment_tb: self-checking bench of the restraint moment
// Drives orientation and angular velocity transactions through the command
// port, computes each expected moment, angle and alignment flag in the
// bench, and compares every result strobe with the oldest expectation.
// Register settings change between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module angular_spring_damper_moment_tb;
	import asdm_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 48;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam logic [31:0] UNIT         = 32'h4000_0000;

	typedef struct {
		logic [47:0] mx;
		logic [47:0] my;
		logic [47:0] mz;
		logic [30:0] ang;
		logic        alg;
	} moment_rec_t;

	logic clk, arst_n, start, busy;
	logic signed [31:0] rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz;
	logic signed [31:0] rot_zx, rot_zy, rot_zz, omega_x, omega_y, omega_z;
	logic psel, penable, pwrite, pready, done, aligned;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic signed [47:0] moment_x, moment_y, moment_z;
	logic [30:0] angle;

	// Shadow copy of the register file.
	logic [31:0] ref_dir [3];
	logic [31:0] stiff_gain, damp_gain;
	logic [30:0] align_thr;

	moment_rec_t expected_moments[$];
	int unsigned mismatch_count, cycle_count, idle_pct;

	angular_spring_damper_moment dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Arctangent steps of the angle search, Q1.30.
	function automatic longint atan_step(int k);
		longint steps [30] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
		return steps[k];
	endfunction

	function automatic longint clip_unit(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Angle of a Q1.30 cosine, Q2.29, by vectoring rotation.
	function automatic longint arc_cosine(longint c);
		longint s, x, y, z, nx, ny, t;
		s = longint'(int_sqrt(64'(64'sd1152921504606846976 - c * c)));
		x = c * 268435456;
		y = s * 268435456;
		z = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = HALF_PI_Q30;
		end
		for (int i = 0; i < 30; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + atan_step(i);
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - atan_step(i);
			end
			x = nx;
			y = ny;
		end
		if (z < 0) z = 0;
		if (z > PI_Q30) z = PI_Q30;
		z = (z + 1) >>> 1;
		return (z > ANGLE_MAX) ? longint'(ANGLE_MAX) : z;
	endfunction

	function automatic longint scaled_round(logic [63:0] p, logic [63:0] q, int n, bit neg);
		logic [63:0] r;
		r = (p * q + (64'd1 << (n - 1))) >> n;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// Expected result of one transaction under the current register shadow.
	function automatic moment_rec_t predict_moment(logic [31:0] rot [9], logic [31:0] om [3]);
		moment_rec_t res;
		longint rm [9], d [3], c [3], a [3], w [3], ax [3], theta, ts, td, m;
		logic [63:0] m2, mag, ua, q, k;
		bit is_aligned;
		for (int i = 0; i < 9; i++) rm[i] = clip_unit(longint'(signed'(rot[i])));
		for (int i = 0; i < 3; i++) begin
			w[i] = longint'(signed'(om[i]));
			d[i] = clip_unit(longint'(signed'(ref_dir[i])));
			ax[i] = 0;
		end
		for (int i = 0; i < 3; i++)
			c[i] = clip_unit((rm[3*i] * d[0] + rm[3*i+1] * d[1] + rm[3*i+2] * d[2]
				+ 64'sd536870912) >>> 30);
		a[0] = (d[1] * c[2] - d[2] * c[1] + 64'sd536870912) >>> 30;
		a[1] = (d[2] * c[0] - d[0] * c[2] + 64'sd536870912) >>> 30;
		a[2] = (d[0] * c[1] - d[1] * c[0] + 64'sd536870912) >>> 30;
		m2 = 64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]);
		mag = int_sqrt(m2);
		is_aligned = (mag <= {33'd0, align_thr});
		theta = 0;
		if (!is_aligned) begin
			for (int i = 0; i < 3; i++) begin
				ua = 64'((a[i] < 0) ? -a[i] : a[i]);
				q = ((ua << 30) + (mag >> 1)) / mag;
				ax[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
			end
			theta = arc_cosine(clip_unit((c[0] * d[0] + c[1] * d[1] + c[2] * d[2]
				+ 64'sd536870912) >>> 30));
		end
		k = ({32'd0, stiff_gain} * 64'(theta) + (64'd1 << 28)) >> 29;
		for (int i = 0; i < 3; i++) begin
			ts = scaled_round(k, 64'((ax[i] < 0) ? -ax[i] : ax[i]), 30, ax[i] < 0);
			td = scaled_round({32'd0, damp_gain}, 64'((w[i] < 0) ? -w[i] : w[i]), 16,
				w[i] < 0);
			m = -ts - td;
			if (m > 64'sd140737488355327) m = 64'sd140737488355327;
			if (m < -64'sd140737488355328) m = -64'sd140737488355328;
			case (i)
				0: res.mx = m[47:0];
				1: res.my = m[47:0];
				default: res.mz = m[47:0];
			endcase
		end
		res.ang = theta[30:0];
		res.alg = is_aligned;
		return res;
	endfunction

	// Compare each result strobe with the oldest expectation.
	always @(posedge clk) begin
		moment_rec_t exp_r;
		if (arst_n && done) begin
			if (expected_moments.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("Unexpected result transaction");
			end else begin
				exp_r = expected_moments.pop_front();
				if (moment_x !== exp_r.mx || moment_y !== exp_r.my || moment_z !== exp_r.mz
					|| angle !== exp_r.ang || aligned !== exp_r.alg) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: exp m=%h %h %h ang=%0d al=%b got m=%h %h %h ang=%0d al=%b",
							exp_r.mx, exp_r.my, exp_r.mz, exp_r.ang, exp_r.alg,
							moment_x, moment_y, moment_z, angle, aligned);
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Write one register through a setup and an access cycle.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_REF_X:     ref_dir[0] = value;
			REG_REF_Y:     ref_dir[1] = value;
			REG_REF_Z:     ref_dir[2] = value;
			REG_STIFFNESS: stiff_gain = value;
			REG_DAMPING:   damp_gain = value;
			REG_THRESHOLD: align_thr = value[30:0];
			default: ;
		endcase
	endtask

	// Wait until the pipeline is empty.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (expected_moments.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
		logic [31:0] stf, logic [31:0] dmp, logic [31:0] thr);
		drain_pipeline();
		write_reg(REG_REF_X, rx);
		write_reg(REG_REF_Y, ry);
		write_reg(REG_REF_Z, rz);
		write_reg(REG_STIFFNESS, stf);
		write_reg(REG_DAMPING, dmp);
		write_reg(REG_THRESHOLD, thr);
	endtask

	// Send one transaction, then idle at random per the current profile.
	task automatic send_item(logic [31:0] rot [9], logic [31:0] om [3]);
		start <= 1'b1;
		{rot_xx, rot_xy, rot_xz} <= {rot[0], rot[1], rot[2]};
		{rot_yx, rot_yy, rot_yz} <= {rot[3], rot[4], rot[5]};
		{rot_zx, rot_zy, rot_zz} <= {rot[6], rot[7], rot[8]};
		{omega_x, omega_y, omega_z} <= {om[0], om[1], om[2]};
		do @(posedge clk); while (busy);
		expected_moments.push_back(predict_moment(rot, om));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] unit_value();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
			2: return $urandom_range(1) ? UNIT : -UNIT;
			default: return 32'($urandom_range(2047)) - 32'd1024;
		endcase
	endfunction

	function automatic logic [31:0] omega_value();
		case ($urandom_range(2))
			0: return $urandom();
			1: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
			default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] rot [9];
		logic [31:0] om [3];
		logic [31:0] fills [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, UNIT};
		set_config(UNIT, 32'd0, 32'd0, 32'h0001_0000, 32'h0000_8000, 32'd1);
		om = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000};
		// Identity, inverted identity (anti-aligned), and quarter turns about z and y.
		rot = '{UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT};
		send_item(rot, om);
		rot = '{-UNIT, 0, 0, 0, -UNIT, 0, 0, 0, -UNIT};
		send_item(rot, om);
		rot = '{0, -UNIT, 0, UNIT, 0, 0, 0, 0, UNIT};
		send_item(rot, om);
		rot = '{0, 0, UNIT, 0, UNIT, 0, -UNIT, 0, 0};
		send_item(rot, om);
		// Out-of-range, zero and all-unit matrices.
		foreach (fills[f]) begin
			foreach (rot[i]) rot[i] = fills[f];
			om = '{fills[f], ~fills[f], 32'd1};
			send_item(rot, om);
		end
		// Largest gains with extreme velocities saturate the moment.
		set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0);
		rot = '{0, UNIT, 0, -UNIT, 0, 0, 0, 0, UNIT};
		foreach (fills[f]) begin
			om = '{fills[f], fills[(f + 1) % 4], fills[(f + 2) % 4]};
			send_item(rot, om);
		end
		// Thresholds at one and above one flag everything as aligned.
		set_config(0, 0, UNIT, 32'h0100_0000, 32'd1, UNIT);
		send_item(rot, om);
		set_config(0, UNIT, 0, 32'd1, 32'd0, 32'h7FFF_FFFF);
		send_item(rot, om);
		rot = '{UNIT, 1000, -1000, -1000, UNIT, 0, 500, 0, UNIT};
		set_config(0, UNIT, 0, 32'h0004_0000, 32'd3, 32'd0);
		send_item(rot, om);
		send_item(rot, '{32'd0, 32'd0, 32'd0});
	endtask

	task automatic test_random(int unsigned count);
		logic [31:0] rot [9];
		logic [31:0] om [3];
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(3))
				0: foreach (rot[i]) rot[i] = unit_value();
				1: begin
					// Near-identity matrix, close to alignment.
					foreach (rot[i])
						rot[i] = ((i % 4) == 0 ? UNIT : 32'd0)
							+ 32'($urandom_range(4095)) - 32'd2048;
				end
				2: begin
					// Signed permutation matrix.
					int p;
					p = $urandom_range(2);
					foreach (rot[i]) rot[i] = 32'd0;
					for (int r = 0; r < 3; r++)
						rot[3*r + (p + r) % 3] = $urandom_range(1) ? UNIT : -UNIT;
				end
				default: foreach (rot[i]) rot[i] = $urandom();
			endcase
			foreach (om[i]) om[i] = omega_value();
			send_item(rot, om);
		end
	endtask

	task automatic random_config();
		set_config(unit_value(), unit_value(), unit_value(),
			$urandom_range(1) ? $urandom() : 32'($urandom_range(32'h0010_0000)),
			$urandom_range(1) ? $urandom() : 32'($urandom_range(32'h0001_0000)),
			$urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(64)));
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		{rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz} <= '0;
		{rot_zx, rot_zy, rot_zz, omega_x, omega_y, omega_z} <= '0;
		ref_dir = '{UNIT, 32'd0, 32'd0};
		stiff_gain = 0;
		damp_gain = 0;
		align_thr = 31'd1;
		mismatch_count = 0;
		cycle_count = 0;
		idle_pct = 19;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph < 2) ? 19 : (ph < 4) ? 54 : 0;
			random_config();
			test_random(250);
		end
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/asdm_pkg.sv
rtl/asdm_front.sv
rtl/asdm_sqrt.sv
rtl/asdm_iter.sv
rtl/asdm_back.sv
rtl/angular_spring_damper_moment.sv
tb/angular_spring_damper_moment_tb.sv
